FILE: sv/rnlg_pkg.sv
// Shared types and constants of the RTP NACK list generator.
`default_nettype none
package rnlg_pkg;

   typedef struct packed {
      logic        operation;
      logic [15:0] seq_num;
      logic [62:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [15:0] nack_seq;
      logic        group_end;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] seq;
      logic [62:0] sent_ms;
      logic [7:0]  retries;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_STEP,
      S_END
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MODE_COUNT,
      MODE_WRITE,
      MODE_REMOVE,
      MODE_TICK
   } pass_mode_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_OLDER,
      KIND_NEWER,
      KIND_TICK
   } item_kind_type;

   typedef struct packed {
      logic          load;
      logic          init;
      logic          step;
      logic          finish_count;
      logic          commit;
      pass_mode_type mode;
   } dp_cmd_type;

   typedef struct packed {
      item_kind_type kind;
      logic          empty;
      logic          gap_zero;
      logic          pass_end;
      logic          adv_old;
   } dp_status_type;

   localparam logic        CSR_RTT_MS      = 1'b0;
   localparam logic        CSR_RETRY_LIMIT = 1'b1;
   localparam logic        OP_PACKET       = 1'b0;
   localparam logic        OP_TICK         = 1'b1;
   localparam logic [15:0] RTT_RESET       = 16'd100;
   localparam logic [7:0]  RETRY_RESET     = 8'd10;
   localparam logic [7:0]  RETRY_MAX       = 8'hFF;
   localparam logic [15:0] GROUP_SPAN      = 16'd15;

endpackage
`default_nettype wire

FILE: sv/rnlg_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module rnlg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire logic                   wr_en,
   input  wire logic [AW-1:0]          wr_addr,
   input  wire logic [WIDTH-1:0]       wr_data,
   input  wire logic [AW-1:0]          rd_addr,
   output logic      [WIDTH-1:0]       rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: sv/rnlg_ctrl.sv
// Controller state machine sequencing the table passes.
`default_nettype none
module rnlg_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire rnlg_pkg::dp_status_type status,
   output rnlg_pkg::dp_cmd_type        cmd
);
   rnlg_pkg::ctrl_state_type state_ff, state_in;
   rnlg_pkg::pass_mode_type  mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rnlg_pkg::S_IDLE;
         mode_ff  <= rnlg_pkg::MODE_TICK;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      cmd      = '0;
      cmd.mode = mode_ff;
      case (state_ff)
         rnlg_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = rnlg_pkg::S_DECODE;
            end
         end
         rnlg_pkg::S_DECODE: begin
            state_in = rnlg_pkg::S_IDLE;
            case (status.kind)
               rnlg_pkg::KIND_TICK: begin
                  if (!status.empty) begin
                     mode_in  = rnlg_pkg::MODE_TICK;
                     cmd.init = 1'b1;
                     state_in = rnlg_pkg::S_READ;
                  end
               end
               rnlg_pkg::KIND_OLDER: begin
                  if (!status.empty) begin
                     mode_in  = rnlg_pkg::MODE_REMOVE;
                     cmd.init = 1'b1;
                     state_in = rnlg_pkg::S_READ;
                  end
               end
               rnlg_pkg::KIND_NEWER: begin
                  if (!status.gap_zero) begin
                     mode_in  = rnlg_pkg::MODE_COUNT;
                     cmd.init = 1'b1;
                     state_in = rnlg_pkg::S_READ;
                  end
               end
               default: state_in = rnlg_pkg::S_IDLE;
            endcase
         end
         rnlg_pkg::S_READ: begin
            state_in = rnlg_pkg::S_STEP;
         end
         rnlg_pkg::S_STEP: begin
            if (status.pass_end) begin
               state_in = rnlg_pkg::S_END;
            end else begin
               cmd.step = 1'b1;
               state_in = status.adv_old ? rnlg_pkg::S_READ : rnlg_pkg::S_STEP;
            end
         end
         rnlg_pkg::S_END: begin
            if (mode_ff == rnlg_pkg::MODE_COUNT) begin
               cmd.finish_count = 1'b1;
               cmd.init         = 1'b1;
               mode_in          = rnlg_pkg::MODE_WRITE;
               state_in         = rnlg_pkg::S_READ;
            end else begin
               cmd.commit = 1'b1;
               state_in   = rnlg_pkg::S_IDLE;
            end
         end
         default: state_in = rnlg_pkg::S_IDLE;
      endcase
   end

   assign busy = (state_ff != rnlg_pkg::S_IDLE);
endmodule
`default_nettype wire

FILE: sv/rnlg_datapath.sv
// Datapath: registers, ping-pong table memory, merge, filter and emission logic.
`default_nettype none
module rnlg_datapath #(
   parameter int DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rnlg_pkg::dp_cmd_type   cmd,
   output rnlg_pkg::dp_status_type     status,
   input  wire rnlg_pkg::req_type      req_data,
   input  wire logic                   csr_we,
   input  wire logic                   csr_index,
   input  wire logic [15:0]            csr_wdata,
   output logic                        rsp_valid,
   output rnlg_pkg::rsp_type           rsp_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int TW = $clog2(2 * DEPTH + 1);
   localparam int RAM_DEPTH = 2 ** (AW + 1);
   localparam int EW = $bits(rnlg_pkg::entry_type);
   localparam logic [16:0] DEPTH_W = 17'(DEPTH);
   localparam logic [TW-1:0] DEPTH_T = TW'(DEPTH);

   logic [15:0]             rtt_ff;
   logic [7:0]              retry_ff;
   logic                    started_ff;
   logic [15:0]             high_ff;
   rnlg_pkg::item_kind_type kind_ff;
   logic [CW-1:0]           gap_ff;
   logic [15:0]             seq_ff;
   logic [62:0]             now_ff;
   logic                    bank_ff;
   logic [CW-1:0]           cnt_ff;
   logic [CW-1:0]           rd_ptr_ff;
   logic [CW-1:0]           gen_ptr_ff;
   logic [CW-1:0]           wr_ptr_ff;
   logic [TW-1:0]           total_ff;
   logic [TW-1:0]           skip_ff;
   logic                    pend_valid_ff;
   rnlg_pkg::rsp_type       pend_ff;
   logic [1:0]              gsize_ff;
   logic [15:0]             first_ff;
   logic                    rsp_valid_ff;
   rnlg_pkg::rsp_type       rsp_ff;

   logic [15:0]             back_dist;
   logic [15:0]             fwd_m1;
   logic [CW-1:0]           gap_in;
   logic [15:0]             gen_k16;
   logic [15:0]             gap16;
   logic [15:0]             gen_val;
   logic                    old_ok;
   logic                    gen_ok;
   logic                    take_old;
   logic                    take_new;
   logic                    insert_mode;
   rnlg_pkg::entry_type     old;
   rnlg_pkg::entry_type     merged;
   rnlg_pkg::entry_type     updated;
   logic [EW-1:0]           rd_raw;
   logic                    we;
   rnlg_pkg::entry_type     wdata;
   logic                    keep;
   logic                    due;
   logic [63:0]             age;
   logic [1:0]              gsize_new;
   logic [15:0]             first_new;
   logic                    close;
   logic                    emit_step;
   logic                    emit_final;

   rnlg_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr ({~bank_ff, wr_ptr_ff[AW-1:0]}),
      .wr_data (wdata),
      .rd_addr ({bank_ff, rd_ptr_ff[AW-1:0]}),
      .rd_data (rd_raw)
   );

   assign old = rd_raw;

   always_comb begin
      back_dist = high_ff - req_data.seq_num;
      fwd_m1    = req_data.seq_num - high_ff - 16'd1;
      gap_in    = ({1'b0, fwd_m1} > DEPTH_W) ? CW'(DEPTH) : CW'(fwd_m1);
   end

   always_comb begin
      insert_mode = (cmd.mode == rnlg_pkg::MODE_COUNT) || (cmd.mode == rnlg_pkg::MODE_WRITE);
      gen_k16 = 16'(gen_ptr_ff);
      gap16   = 16'(gap_ff);
      if (seq_ff < gap16) begin
         gen_val = (gen_k16 < seq_ff) ? gen_k16 : (gen_k16 - gap16);
      end else begin
         gen_val = seq_ff - gap16 + gen_k16;
      end
      old_ok   = rd_ptr_ff < cnt_ff;
      gen_ok   = insert_mode && (gen_ptr_ff < gap_ff);
      take_old = old_ok && (!gen_ok || (old.seq <= gen_val));
      take_new = gen_ok && (!old_ok || (gen_val <= old.seq));
      merged.seq     = take_old ? old.seq : gen_val;
      merged.sent_ms = take_old ? old.sent_ms : 63'd0;
      merged.retries = take_old ? old.retries : 8'd0;

      keep = old.retries <= retry_ff;
      age  = {1'b0, now_ff} - {1'b0, old.sent_ms};
      due  = !age[63] && (age[62:0] >= {47'd0, rtt_ff});
      updated.seq     = old.seq;
      updated.sent_ms = now_ff;
      updated.retries = (old.retries == rnlg_pkg::RETRY_MAX) ? rnlg_pkg::RETRY_MAX
                                                              : old.retries + 8'd1;
      gsize_new = (gsize_ff == 2'd0) ? 2'd1 : 2'd2;
      first_new = (gsize_ff == 2'd0) ? old.seq : first_ff;
      close     = (gsize_ff != 2'd0) && ((old.seq - first_new) >= rnlg_pkg::GROUP_SPAN);

      emit_step  = cmd.step && (cmd.mode == rnlg_pkg::MODE_TICK) && keep && due
                   && pend_valid_ff;
      emit_final = cmd.commit && (cmd.mode == rnlg_pkg::MODE_TICK) && pend_valid_ff;

      we    = 1'b0;
      wdata = merged;
      if (cmd.step) begin
         case (cmd.mode)
            rnlg_pkg::MODE_WRITE:  we = (skip_ff == '0);
            rnlg_pkg::MODE_REMOVE: begin
               we    = old.seq != seq_ff;
               wdata = old;
            end
            rnlg_pkg::MODE_TICK: begin
               we    = keep;
               wdata = due ? updated : old;
            end
            default: we = 1'b0;
         endcase
      end

      status.kind     = kind_ff;
      status.empty    = cnt_ff == '0;
      status.gap_zero = gap_ff == '0;
      status.pass_end = !old_ok && !gen_ok;
      status.adv_old  = insert_mode ? take_old : old_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rtt_ff        <= rnlg_pkg::RTT_RESET;
         retry_ff      <= rnlg_pkg::RETRY_RESET;
         started_ff    <= 1'b0;
         high_ff       <= '0;
         kind_ff       <= rnlg_pkg::KIND_NONE;
         gap_ff        <= '0;
         bank_ff       <= 1'b0;
         cnt_ff        <= '0;
         rd_ptr_ff     <= '0;
         gen_ptr_ff    <= '0;
         wr_ptr_ff     <= '0;
         total_ff      <= '0;
         skip_ff       <= '0;
         pend_valid_ff <= 1'b0;
         gsize_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= emit_step || emit_final;
         if (csr_we) begin
            case (csr_index)
               rnlg_pkg::CSR_RTT_MS:      rtt_ff   <= csr_wdata;
               rnlg_pkg::CSR_RETRY_LIMIT: retry_ff <= csr_wdata[7:0];
               default:                   rtt_ff   <= rtt_ff;
            endcase
         end
         if (cmd.load) begin
            if (req_data.operation == rnlg_pkg::OP_TICK) begin
               kind_ff <= rnlg_pkg::KIND_TICK;
            end else if (!started_ff) begin
               kind_ff    <= rnlg_pkg::KIND_NONE;
               started_ff <= 1'b1;
               high_ff    <= req_data.seq_num;
            end else if (back_dist == 16'd0) begin
               kind_ff <= rnlg_pkg::KIND_NONE;
            end else if (!back_dist[15]) begin
               kind_ff <= rnlg_pkg::KIND_OLDER;
            end else begin
               kind_ff <= rnlg_pkg::KIND_NEWER;
               high_ff <= req_data.seq_num;
               gap_ff  <= gap_in;
            end
         end
         if (cmd.init) begin
            rd_ptr_ff     <= '0;
            gen_ptr_ff    <= '0;
            wr_ptr_ff     <= '0;
            total_ff      <= '0;
            pend_valid_ff <= 1'b0;
            gsize_ff      <= '0;
         end
         if (cmd.finish_count) begin
            skip_ff <= (total_ff > DEPTH_T) ? total_ff - DEPTH_T : '0;
         end
         if (cmd.step) begin
            if (status.adv_old) begin
               rd_ptr_ff <= rd_ptr_ff + CW'(1);
            end
            if (take_new) begin
               gen_ptr_ff <= gen_ptr_ff + CW'(1);
            end
            case (cmd.mode)
               rnlg_pkg::MODE_COUNT: total_ff <= total_ff + TW'(1);
               rnlg_pkg::MODE_WRITE: begin
                  if (skip_ff != '0) begin
                     skip_ff <= skip_ff - TW'(1);
                  end else begin
                     wr_ptr_ff <= wr_ptr_ff + CW'(1);
                  end
               end
               rnlg_pkg::MODE_REMOVE: begin
                  if (we) begin
                     wr_ptr_ff <= wr_ptr_ff + CW'(1);
                  end
               end
               rnlg_pkg::MODE_TICK: begin
                  if (keep) begin
                     wr_ptr_ff <= wr_ptr_ff + CW'(1);
                     if (due) begin
                        if (pend_valid_ff) begin
                           rsp_ff <= pend_ff;
                        end
                        pend_valid_ff     <= 1'b1;
                        pend_ff.nack_seq  <= old.seq;
                        pend_ff.group_end <= close;
                        pend_ff.last      <= 1'b0;
                        first_ff          <= first_new;
                        gsize_ff          <= close ? 2'd0 : gsize_new;
                     end
                  end
               end
               default: total_ff <= total_ff;
            endcase
         end
         if (cmd.commit) begin
            bank_ff <= ~bank_ff;
            cnt_ff  <= wr_ptr_ff;
            if (emit_final) begin
               rsp_ff.nack_seq    <= pend_ff.nack_seq;
               rsp_ff.group_end   <= 1'b1;
               rsp_ff.last        <= 1'b1;
               pend_valid_ff      <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         seq_ff <= req_data.seq_num;
         now_ff <= req_data.now_ms;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

FILE: sv/rtp_nack_list_generator_top.sv
// Top level of the RTP NACK list generator.
//
// A transaction is started by raising start while busy is low; req_data then
// carries a received packet (operation 0) or a timer tick (operation 1).
// Busy stays high until the transaction has been fully processed.
// The missing-number table lives in a ping-pong memory; every operation that
// changes it copies the table from one half into the other in ascending order.
// Each pass reads every stored entry from memory and then merges it in a step;
// a gap number needs only a step. A packet with a gap runs a counting pass and
// a writing pass; a removal or a tick runs one pass; other packets run no pass.
// A tick delivers its results on rsp_valid / rsp_data, one cycle each, in
// ascending order; the final one carries last and is on the ports in the
// first cycle in which busy is low again. The receiver cannot stall the results.
// Registers are written on the csr_ port and take effect at once; the user must
// write them only while idle, as the block itself does not enforce it.
// Synchronous reset empties the table, clears the first-packet flag and
// restores the register defaults; no clearing pass is needed.
`default_nettype none
module rtp_nack_list_generator_top #(
   parameter int DEPTH = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire rnlg_pkg::req_type req_data,
   output logic                   rsp_valid,
   output rnlg_pkg::rsp_type      rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata
);
   rnlg_pkg::dp_cmd_type    cmd;
   rnlg_pkg::dp_status_type status;

   rnlg_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   rnlg_datapath #(.DEPTH(DEPTH)) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule
`default_nettype wire

FILE: sv/rnlg_checker.sv
// Port-level checker of the RTP NACK list generator and its bind.
`default_nettype none
module rnlg_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_valid,
   input wire rnlg_pkg::rsp_type rsp_data
);
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_rsp_in_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result outside a transaction");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.group_end)
      else $error("final result does not close its group");

   a_last_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |=> !rsp_valid)
      else $error("result after the final one");
endmodule

bind rtp_nack_list_generator_top rnlg_checker u_rnlg_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
`default_nettype wire

FILE: tb/rtp_nack_list_generator_top_tb.sv
// Self-checking testbench of the RTP NACK list generator, with a predicting scoreboard.
`default_nettype none
module rtp_nack_list_generator_top_tb;

   localparam int DEPTH = 64;

   class nack_scoreboard;
      logic [15:0]         rtt;
      logic [7:0]          retry_lim;
      bit                  started;
      logic [15:0]         highest;
      rnlg_pkg::entry_type table_q[$];
      rnlg_pkg::rsp_type   pending_q[$];
      int                  mismatches;
      int                  nacks_seen;

      function void clear();
         rtt = rnlg_pkg::RTT_RESET;
         retry_lim = rnlg_pkg::RETRY_RESET;
         started = 0;
         highest = 0;
         table_q.delete();
         pending_q.delete();
      endfunction

      function void add_missing(logic [15:0] s);
         int pos;
         rnlg_pkg::entry_type e;
         pos = 0;
         while (pos < table_q.size() && table_q[pos].seq < s) pos++;
         if (pos < table_q.size() && table_q[pos].seq == s) return;
         if (table_q.size() >= DEPTH) begin
            if (pos == 0) return;
            void'(table_q.pop_front());
            pos--;
         end
         e.seq = s;
         e.sent_ms = '0;
         e.retries = '0;
         table_q.insert(pos, e);
      endfunction

      function void note_request(rnlg_pkg::req_type r);
         logic [15:0] back_dist, gap;
         int n, pos, k;
         logic [15:0] first;
         int gsize;
         rnlg_pkg::rsp_type o;
         rnlg_pkg::entry_type keep_q[$];
         if (r.operation == rnlg_pkg::OP_PACKET) begin
            if (!started) begin
               started = 1;
               highest = r.seq_num;
               return;
            end
            if (r.seq_num == highest) return;
            back_dist = highest - r.seq_num;
            if (back_dist < 16'h8000) begin
               foreach (table_q[i])
                  if (table_q[i].seq == r.seq_num) begin
                     table_q.delete(i);
                     break;
                  end
               return;
            end
            gap = r.seq_num - highest;
            n = int'(gap) - 1;
            if (n > DEPTH) n = DEPTH;
            highest = r.seq_num;
            for (k = n; k >= 1; k--) add_missing(r.seq_num - 16'(k));
         end else begin
            gsize = 0;
            first = 0;
            pos = 0;
            foreach (table_q[i]) begin
               rnlg_pkg::entry_type e;
               e = table_q[i];
               if (e.retries > retry_lim) continue;
               if (r.now_ms >= e.sent_ms && r.now_ms - e.sent_ms >= 63'(rtt)) begin
                  e.sent_ms = r.now_ms;
                  if (e.retries != rnlg_pkg::RETRY_MAX) e.retries++;
                  if (gsize == 0) first = e.seq;
                  gsize++;
                  o.nack_seq = e.seq;
                  o.group_end = 0;
                  o.last = 0;
                  if (gsize > 1 && e.seq - first >= rnlg_pkg::GROUP_SPAN) begin
                     o.group_end = 1;
                     gsize = 0;
                  end
                  pending_q = {pending_q, o};
                  pos++;
               end
               keep_q = {keep_q, e};
            end
            table_q = keep_q;
            if (pos > 0) begin
               pending_q[pending_q.size() - 1].group_end = 1;
               pending_q[pending_q.size() - 1].last = 1;
            end
         end
      endfunction

      function void check_result(rnlg_pkg::rsp_type got);
         rnlg_pkg::rsp_type want;
         nacks_seen++;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: seq %0d group_end %0b last %0b",
                        got.nack_seq, got.group_end, got.last);
            return;
         end
         want = pending_q.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Mismatch: expected seq %0d ge %0b last %0b, got seq %0d ge %0b last %0b",
                        want.nack_seq, want.group_end, want.last,
                        got.nack_seq, got.group_end, got.last);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              start = 0;
   logic              busy;
   rnlg_pkg::req_type req_data = '0;
   logic              rsp_valid;
   rnlg_pkg::rsp_type rsp_data;
   logic              csr_we = 0;
   logic              csr_index = rnlg_pkg::CSR_RTT_MS;
   logic [15:0]       csr_wdata = '0;

   nack_scoreboard sb;
   int          items_sent;
   int          ticks_sent;
   bit          quiet;
   logic [62:0] clock_ms;
   logic [15:0] next_seq;

   rtp_nack_list_generator_top #(.DEPTH(DEPTH)) dut (
      .clock, .reset, .start, .busy, .req_data, .rsp_valid, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   always #4 clock = ~clock;

   always @(posedge clock)
      if (!reset && rsp_valid) sb.check_result(rsp_data);

   task automatic send_item(logic op, logic [15:0] s, logic [62:0] t);
      rnlg_pkg::req_type r;
      r.operation = op;
      r.seq_num = s;
      r.now_ms = t;
      while (!quiet && $urandom_range(99) < 7) @(posedge clock);
      start <= 1;
      req_data <= r;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      sb.note_request(r);
      start <= 0;
      items_sent++;
      if (op == rnlg_pkg::OP_TICK) ticks_sent++;
      @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [15:0] v);
      while (sb.pending_q.size() != 0 || busy) @(posedge clock);
      repeat (300) @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= v;
      if (idx == rnlg_pkg::CSR_RTT_MS) sb.rtt = v;
      else sb.retry_lim = v[7:0];
      @(posedge clock);
      csr_we <= 0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      logic [62:0] step_ms;
      pick = $urandom_range(99);
      if (pick < 40) begin
         next_seq = next_seq + 16'($urandom_range(1, ($urandom_range(9) == 0) ? 80 : 6));
         send_item(rnlg_pkg::OP_PACKET, next_seq, 63'({$urandom, $urandom}));
      end else if (pick < 60) begin
         send_item(rnlg_pkg::OP_PACKET, next_seq - 16'($urandom_range(0, 70)), '0);
      end else if (pick < 65) begin
         next_seq = 16'($urandom);
         send_item(rnlg_pkg::OP_PACKET, next_seq, '0);
      end else begin
         step_ms = ($urandom_range(19) == 0) ? 63'({$urandom, $urandom})
                                             : 63'($urandom_range(0, 300));
         if ($urandom_range(29) == 0) clock_ms = clock_ms - step_ms;
         else clock_ms = clock_ms + step_ms;
         send_item(rnlg_pkg::OP_TICK, 16'($urandom), clock_ms);
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      quiet = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: first packet, duplicate, wrapped gap, long gap, removals, ticks.
      send_item(rnlg_pkg::OP_PACKET, 16'hFFFA, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'hFFFA, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h0003, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'hFFFC, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h0100, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h00F0, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h0002, '0);
      send_item(rnlg_pkg::OP_TICK, 16'hFFFF, 63'd50);
      send_item(rnlg_pkg::OP_TICK, '0, 63'd500);
      send_item(rnlg_pkg::OP_TICK, '0, 63'd520);
      send_item(rnlg_pkg::OP_TICK, '0, 63'd10);
      send_item(rnlg_pkg::OP_PACKET, 16'h8100, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h0100, '0);
      send_item(rnlg_pkg::OP_TICK, '0, 63'h7FFF_FFFF_FFFF_FFFF);
      send_item(rnlg_pkg::OP_PACKET, 16'h8101, '0);
      send_item(rnlg_pkg::OP_PACKET, 16'h8103, '0);
      send_item(rnlg_pkg::OP_TICK, '0, 63'h7FFF_FFFF_FFFF_FFFF);
      write_reg(rnlg_pkg::CSR_RTT_MS, 16'd0);
      write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd0);
      send_item(rnlg_pkg::OP_TICK, '0, 63'h7FFF_FFFF_FFFF_FFFF);
      send_item(rnlg_pkg::OP_TICK, '0, 63'h7FFF_FFFF_FFFF_FFFF);

      next_seq = 16'h8103;
      clock_ms = 63'd1000;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'd0);
                     write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd255); end
            1: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'd65535);
                     write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd3); end
            2: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'd100);
                     write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd10); end
            3: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'($urandom_range(0, 250)));
                     write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'($urandom_range(0, 20))); end
            4: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'd1);
                     write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd0); end
            default: begin write_reg(rnlg_pkg::CSR_RTT_MS, 16'd50);
                           write_reg(rnlg_pkg::CSR_RETRY_LIMIT, 16'd255); end
         endcase
         quiet = (phase == 2);
         for (int i = 0; i < 67; i++) random_item();
      end
      quiet = 0;

      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      $display("Run covered %0d transactions (%0d ticks) and checked %0d NACK results.",
               items_sent, ticks_sent, sb.nacks_seen);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("PASS rtp_nack_list_generator_top");
      else
         $display("FAIL rtp_nack_list_generator_top");
      $finish;
   end

   initial begin
      #8000000;
      $display("FAIL rtp_nack_list_generator_top");
      $finish;
   end
endmodule
`default_nettype wire

FILE: filelist.f
sv/rnlg_pkg.sv
sv/rnlg_ram.sv
sv/rnlg_ctrl.sv
sv/rnlg_datapath.sv
sv/rtp_nack_list_generator_top.sv
sv/rnlg_checker.sv
tb/rtp_nack_list_generator_top_tb.sv
